// ===== rtl/spp_pkg.sv =====
// ----------------------------------------------------------------------------
// spp_pkg: shared types and constants for the shape pair penetration block
// Pair kinds, step counts of the root and divider pipelines, and the
// sideband record that travels with every request down the pipeline.
// ----------------------------------------------------------------------------
package spp_pkg;

    typedef enum logic [1:0] {
        OP_BOX_BOX       = 2'd0,
        OP_CIRCLE_CIRCLE = 2'd1,
        OP_BOX_CIRCLE    = 2'd2,
        OP_CIRCLE_BOX    = 2'd3
    } op_t;

    // One result bit per stage: a 64-bit radicand gives a 32-bit root, and
    // the push quotient is known to stay below 2^32.
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;

    typedef struct packed {
        logic               is_bb;      // box-box pair, result fixed at the front
        logic               bb_hit;
        logic signed [31:0] bb_px;
        logic signed [31:0] bb_py;
        logic               miss;       // radial pair known to miss
        logic               zero_push;  // distance is zero, push is zero
        logic               neg_x;      // push x points in the negative direction
        logic               neg_y;
        logic        [31:0] r;          // radius of the radial test
        logic        [31:0] ux;         // |dx|, valid when not a miss
        logic        [31:0] uy;
    } side_t;

endpackage

// ===== rtl/spp_front.sv =====
// ----------------------------------------------------------------------------
// spp_front: pair decode, deltas, box-box result and squared distance
// Five register stages: offsets to the box edges, clamped delta, magnitudes
// and range checks, squares and box-box decision, squared sum.
// ----------------------------------------------------------------------------
module spp_front
    import spp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  op_t                op,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic        [30:0] a_size_x,
    input  logic        [30:0] a_size_y,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic        [30:0] b_size_x,
    input  logic        [30:0] b_size_y,
    output logic               out_valid,
    output logic        [63:0] out_n,
    output side_t              out_side
);

    // Stage A: the circle centre is offset against both box edges.
    logic signed [31:0] bcx, bcy, ccx, ccy;
    logic        [29:0] hw, hh;
    logic        [31:0] r_sel;
    logic        [31:0] sum_w, sum_h;
    logic signed [34:0] thx_next, tlx_next, thy_next, tly_next;

    logic               va_reg;
    logic               bba_reg;
    logic signed [34:0] thx_reg, tlx_reg, thy_reg, tly_reg;
    logic        [31:0] ra_reg;
    logic        [30:0] hxa_reg, hya_reg;

    always_comb begin
        sum_w = {1'b0, a_size_x} + {1'b0, b_size_x};
        sum_h = {1'b0, a_size_y} + {1'b0, b_size_y};
        unique case (op)
            OP_BOX_BOX: begin
                ccx = a_x; ccy = a_y; bcx = b_x; bcy = b_y;
                hw = '0; hh = '0; r_sel = '0;
            end
            OP_CIRCLE_CIRCLE: begin
                ccx = b_x; ccy = b_y; bcx = a_x; bcy = a_y;
                hw = '0; hh = '0; r_sel = sum_w;
            end
            OP_BOX_CIRCLE: begin
                ccx = b_x; ccy = b_y; bcx = a_x; bcy = a_y;
                hw = a_size_x[30:1]; hh = a_size_y[30:1]; r_sel = {1'b0, b_size_x};
            end
            default: begin
                ccx = a_x; ccy = a_y; bcx = b_x; bcy = b_y;
                hw = b_size_x[30:1]; hh = b_size_y[30:1]; r_sel = {1'b0, a_size_x};
            end
        endcase
        thx_next = 35'(ccx) - 35'(bcx) - $signed({5'b0, hw});
        tlx_next = 35'(ccx) - 35'(bcx) + $signed({5'b0, hw});
        thy_next = 35'(ccy) - 35'(bcy) - $signed({5'b0, hh});
        tly_next = 35'(ccy) - 35'(bcy) + $signed({5'b0, hh});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
        end
        if (en) begin
            bba_reg <= (op == OP_BOX_BOX);
            thx_reg <= thx_next;
            tlx_reg <= tlx_next;
            thy_reg <= thy_next;
            tly_reg <= tly_next;
            ra_reg  <= r_sel;
            hxa_reg <= sum_w[31:1];
            hya_reg <= sum_h[31:1];
        end
    end

    // Stage B: delta from the closest point of the box (zero inside it).
    logic signed [34:0] dx_next, dy_next;
    logic               vb_reg, bbb_reg;
    logic signed [34:0] dx_reg, dy_reg;
    logic        [31:0] rb_reg;
    logic        [30:0] hxb_reg, hyb_reg;

    always_comb begin
        if (thx_reg > 0) begin
            dx_next = thx_reg;
        end else if (tlx_reg < 0) begin
            dx_next = tlx_reg;
        end else begin
            dx_next = '0;
        end
        if (thy_reg > 0) begin
            dy_next = thy_reg;
        end else if (tly_reg < 0) begin
            dy_next = tly_reg;
        end else begin
            dy_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
        if (en) begin
            bbb_reg <= bba_reg;
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            rb_reg  <= ra_reg;
            hxb_reg <= hxa_reg;
            hyb_reg <= hya_reg;
        end
    end

    // Stage C: magnitudes, far-apart check and box-box overlaps.
    logic        [34:0] ux_next, uy_next;
    logic               vc_reg, bbc_reg, farc_reg, nxc_reg, nyc_reg;
    logic        [34:0] uxc_reg, uyc_reg;
    logic signed [35:0] ox_reg, oy_reg;
    logic        [31:0] rc_reg;

    always_comb begin
        ux_next = dx_reg[34] ? 35'(-dx_reg) : 35'(dx_reg);
        uy_next = dy_reg[34] ? 35'(-dy_reg) : 35'(dy_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (en) begin
            vc_reg <= vb_reg;
        end
        if (en) begin
            bbc_reg  <= bbb_reg;
            uxc_reg  <= ux_next;
            uyc_reg  <= uy_next;
            farc_reg <= (rb_reg == '0) || (ux_next >= {3'b0, rb_reg})
                        || (uy_next >= {3'b0, rb_reg});
            ox_reg   <= $signed({5'b0, hxb_reg}) - $signed({1'b0, ux_next});
            oy_reg   <= $signed({5'b0, hyb_reg}) - $signed({1'b0, uy_next});
            nxc_reg  <= !(dx_reg > 0);
            nyc_reg  <= !(dy_reg > 0);
            rc_reg   <= rb_reg;
        end
    end

    // Stage D: squares and the box-box push along the smaller overlap.
    logic               bb_hit_next;
    logic signed [31:0] bb_px_next, bb_py_next;
    logic               vd_reg;
    logic        [63:0] sx_reg, sy_reg;
    side_t              sd_reg;

    always_comb begin
        bb_hit_next = (ox_reg > 0) && (oy_reg > 0);
        bb_px_next  = '0;
        bb_py_next  = '0;
        if (bb_hit_next) begin
            if (ox_reg < oy_reg) begin
                bb_px_next = nxc_reg ? -ox_reg[31:0] : ox_reg[31:0];
            end else begin
                bb_py_next = nyc_reg ? -oy_reg[31:0] : oy_reg[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
        end else if (en) begin
            vd_reg <= vc_reg;
        end
        if (en) begin
            sx_reg           <= uxc_reg[31:0] * uxc_reg[31:0];
            sy_reg           <= uyc_reg[31:0] * uyc_reg[31:0];
            sd_reg.is_bb     <= bbc_reg;
            sd_reg.bb_hit    <= bb_hit_next;
            sd_reg.bb_px     <= bb_px_next;
            sd_reg.bb_py     <= bb_py_next;
            sd_reg.miss      <= farc_reg;
            sd_reg.zero_push <= 1'b0;
            sd_reg.neg_x     <= nxc_reg;
            sd_reg.neg_y     <= nyc_reg;
            sd_reg.r         <= rc_reg;
            sd_reg.ux        <= uxc_reg[31:0];
            sd_reg.uy        <= uyc_reg[31:0];
        end
    end

    // Stage E: squared distance; a carry out means the pair is far apart.
    logic [64:0] sum_next;
    side_t       se_next;
    logic        ve_reg;
    logic [63:0] n_reg;
    side_t       se_reg;

    always_comb begin
        sum_next     = {1'b0, sx_reg} + {1'b0, sy_reg};
        se_next      = sd_reg;
        se_next.miss = sd_reg.miss || sum_next[64];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ve_reg <= 1'b0;
        end else if (en) begin
            ve_reg <= vd_reg;
        end
        if (en) begin
            n_reg  <= sum_next[63:0];
            se_reg <= se_next;
        end
    end

    assign out_valid = ve_reg;
    assign out_n     = n_reg;
    assign out_side  = se_reg;

endmodule

// ===== rtl/spp_sqrt.sv =====
// ----------------------------------------------------------------------------
// spp_sqrt: pipelined integer square root
// One root bit per stage, floor of the square root of a 64-bit value.
// ----------------------------------------------------------------------------
module spp_sqrt
    import spp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] in_n,
    input  side_t       in_side,
    output logic        out_valid,
    output logic [31:0] out_root,
    output side_t       out_side
);

    logic        v_reg    [SQRT_STEPS];
    logic [33:0] rem_reg  [SQRT_STEPS];
    logic [31:0] root_reg [SQRT_STEPS];
    logic [63:0] bits_reg [SQRT_STEPS];
    side_t       side_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic        v_prev;
        logic [33:0] rem_prev;
        logic [31:0] root_prev;
        logic [63:0] bits_prev;
        side_t       side_prev;
        logic [35:0] tmp;
        logic [35:0] trial;

        if (k == 0) begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign bits_prev = in_n;
            assign side_prev = in_side;
        end else begin : g_next
            assign v_prev    = v_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign bits_prev = bits_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        assign tmp   = {rem_prev, bits_prev[63:62]};
        assign trial = {2'b0, root_prev, 2'b01};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_prev;
            end
            if (en) begin
                if (tmp >= trial) begin
                    rem_reg[k]  <= 34'(tmp - trial);
                    root_reg[k] <= {root_prev[30:0], 1'b1};
                end else begin
                    rem_reg[k]  <= tmp[33:0];
                    root_reg[k] <= {root_prev[30:0], 1'b0};
                end
                bits_reg[k] <= {bits_prev[61:0], 2'b00};
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[SQRT_STEPS-1];
    assign out_root  = root_reg[SQRT_STEPS-1];
    assign out_side  = side_reg[SQRT_STEPS-1];

endmodule

// ===== rtl/spp_div.sv =====
// ----------------------------------------------------------------------------
// spp_div: pipelined two-lane restoring divider
// Divides both push numerators by the distance, one quotient bit per stage.
// The quotient is known to fit in 32 bits.
// ----------------------------------------------------------------------------
module spp_div
    import spp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] in_num_x,
    input  logic [63:0] in_num_y,
    input  logic [31:0] in_den,
    input  side_t       in_side,
    output logic        out_valid,
    output logic [31:0] out_q_x,
    output logic [31:0] out_q_y,
    output side_t       out_side
);

    logic        v_reg    [DIV_STEPS];
    logic [31:0] remx_reg [DIV_STEPS];
    logic [31:0] remy_reg [DIV_STEPS];
    logic [31:0] lowx_reg [DIV_STEPS];
    logic [31:0] lowy_reg [DIV_STEPS];
    logic [31:0] qx_reg   [DIV_STEPS];
    logic [31:0] qy_reg   [DIV_STEPS];
    logic [31:0] den_reg  [DIV_STEPS];
    side_t       side_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic        v_prev;
        logic [31:0] remx_prev, remy_prev, lowx_prev, lowy_prev;
        logic [31:0] qx_prev, qy_prev, den_prev;
        side_t       side_prev;
        logic [32:0] tx, ty;

        if (k == 0) begin : g_first
            assign v_prev    = in_valid;
            assign remx_prev = in_num_x[63:32];
            assign remy_prev = in_num_y[63:32];
            assign lowx_prev = in_num_x[31:0];
            assign lowy_prev = in_num_y[31:0];
            assign qx_prev   = '0;
            assign qy_prev   = '0;
            assign den_prev  = in_den;
            assign side_prev = in_side;
        end else begin : g_next
            assign v_prev    = v_reg[k-1];
            assign remx_prev = remx_reg[k-1];
            assign remy_prev = remy_reg[k-1];
            assign lowx_prev = lowx_reg[k-1];
            assign lowy_prev = lowy_reg[k-1];
            assign qx_prev   = qx_reg[k-1];
            assign qy_prev   = qy_reg[k-1];
            assign den_prev  = den_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        assign tx = {remx_prev, lowx_prev[31]};
        assign ty = {remy_prev, lowy_prev[31]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_prev;
            end
            if (en) begin
                if (tx >= {1'b0, den_prev}) begin
                    remx_reg[k] <= 32'(tx - {1'b0, den_prev});
                    qx_reg[k]   <= {qx_prev[30:0], 1'b1};
                end else begin
                    remx_reg[k] <= tx[31:0];
                    qx_reg[k]   <= {qx_prev[30:0], 1'b0};
                end
                if (ty >= {1'b0, den_prev}) begin
                    remy_reg[k] <= 32'(ty - {1'b0, den_prev});
                    qy_reg[k]   <= {qy_prev[30:0], 1'b1};
                end else begin
                    remy_reg[k] <= ty[31:0];
                    qy_reg[k]   <= {qy_prev[30:0], 1'b0};
                end
                lowx_reg[k] <= {lowx_prev[30:0], 1'b0};
                lowy_reg[k] <= {lowy_prev[30:0], 1'b0};
                den_reg[k]  <= den_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[DIV_STEPS-1];
    assign out_q_x   = qx_reg[DIV_STEPS-1];
    assign out_q_y   = qy_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule

// ===== rtl/shape_pair_penetration.sv =====
// ----------------------------------------------------------------------------
// shape_pair_penetration: overlap test and penetration vector for 2D pairs
// Box-box, circle-circle, box-circle and circle-box pairs in Q16.16, one
// hit flag and one saturated push vector per request.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_        in         tuser: operation; tdata: a_x, a_y, a_size_x, a_size_y,
//                       b_x, b_y, b_size_x, b_size_y
//  m_        out        tuser: hit; tdata: push_x, push_y
//
// A request is accepted every cycle while s_tready is high. Every request passes
// 71 register stages, in this order: five front stages, 32 root stages (one
// root bit each), one multiply stage, 32 divider stages (one quotient bit each)
// and the output register. The whole pipeline moves as one: when a result
// waits in the output register and the sink holds m_tready low, all stages
// hold and s_tready is low; otherwise the pipeline advances and any bubble is
// filled. Reset is synchronous and clears only the valid bits.
//
module shape_pair_penetration
    import spp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: a_x[31:0], a_y[63:32], a_size_x[94:64], a_size_y[125:95],
    //        b_x[157:126], b_y[189:158], b_size_x[220:190],
    //        b_size_y[251:221], zero fill[255:252]
    input  logic [255:0] s_tdata,
    // tuser: operation[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: push_x[31:0], push_y[63:32]
    output logic [63:0]  m_tdata,
    // tuser: hit[0]
    output logic [0:0]   m_tuser
);

    // The pipeline advances whenever the output register is free or drains.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Front: decode, clamped delta, box-box result and squared distance.
    logic        f_valid;
    logic [63:0] f_n;
    side_t       f_side;

    spp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .op        (op_t'(s_tuser)),
        .a_x       (s_tdata[31:0]),
        .a_y       (s_tdata[63:32]),
        .a_size_x  (s_tdata[94:64]),
        .a_size_y  (s_tdata[125:95]),
        .b_x       (s_tdata[157:126]),
        .b_y       (s_tdata[189:158]),
        .b_size_x  (s_tdata[220:190]),
        .b_size_y  (s_tdata[251:221]),
        .out_valid (f_valid),
        .out_n     (f_n),
        .out_side  (f_side)
    );

    // Distance as the floor of the root of the squared sum.
    logic        r_valid;
    logic [31:0] r_root;
    side_t       r_side;

    spp_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_n      (f_n),
        .in_side   (f_side),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_side  (r_side)
    );

    // Overlap depth and the push numerators |d| * overlap. The overlap is
    // positive for a hit and then below 2^32, so a 32-bit multiply holds it.
    logic [32:0] overlap;
    logic        rad_hit;
    side_t       mside_next;
    logic        m_valid_reg;
    logic [63:0] numx_reg, numy_reg;
    logic [31:0] den_reg;
    side_t       mside_reg;

    assign overlap = {1'b0, r_side.r} - {1'b0, r_root};
    assign rad_hit = !r_side.miss && !overlap[32] && (overlap != '0);

    always_comb begin
        mside_next           = r_side;
        mside_next.miss      = !rad_hit;
        mside_next.zero_push = (r_root == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= r_valid;
        end
        if (en) begin
            numx_reg  <= r_side.ux * overlap[31:0];
            numy_reg  <= r_side.uy * overlap[31:0];
            den_reg   <= r_root;
            mside_reg <= mside_next;
        end
    end

    // Push magnitudes, truncated toward zero.
    logic        d_valid;
    logic [31:0] d_qx, d_qy;
    side_t       d_side;

    spp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (m_valid_reg),
        .in_num_x  (numx_reg),
        .in_num_y  (numy_reg),
        .in_den    (den_reg),
        .in_side   (mside_reg),
        .out_valid (d_valid),
        .out_q_x   (d_qx),
        .out_q_y   (d_qy),
        .out_side  (d_side)
    );

    // Sign and saturate a push magnitude below 2^32.
    function automatic logic [31:0] sat_push(input logic [31:0] q, input logic neg);
        logic [31:0] res;
        if (neg) begin
            res = (q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q);
        end else begin
            res = (q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
        end
        return res;
    endfunction

    logic        hit_next;
    logic [31:0] px_next, py_next;

    always_comb begin
        if (d_side.is_bb) begin
            hit_next = d_side.bb_hit;
            px_next  = d_side.bb_px;
            py_next  = d_side.bb_py;
        end else if (d_side.miss) begin
            hit_next = 1'b0;
            px_next  = '0;
            py_next  = '0;
        end else if (d_side.zero_push) begin
            // Coincident centres or centre inside the box: hit, no direction.
            hit_next = 1'b1;
            px_next  = '0;
            py_next  = '0;
        end else begin
            hit_next = 1'b1;
            px_next  = sat_push(d_qx, d_side.neg_x);
            py_next  = sat_push(d_qy, d_side.neg_y);
        end
    end

    // Output register.
    logic        out_valid_reg;
    logic        hit_reg;
    logic [31:0] px_reg, py_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= d_valid;
        end
        if (en) begin
            hit_reg <= hit_next;
            px_reg  <= px_next;
            py_reg  <= py_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {py_reg, px_reg};
    assign m_tuser[0] = hit_reg;

    // A miss never carries a push.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("push is nonzero on a miss");

    // A result held by the sink does not change.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // The input side is stalled exactly when a result waits and m_tready is low.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the output stall");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule
